/* design/abti_pkg.sv */
// shared types, constants and control structs for the array binary tree block
`default_nettype none

package abti_pkg;

    localparam int SLOT_W        = 6;
    localparam int VAL_W         = 32;
    localparam int ACT_W         = 2;
    localparam int ST_W          = 3;
    localparam int MAX_NODES_DEF = 63;

    localparam logic [SLOT_W-1:0] TREE_SIZE_RST = 6'd63;

    typedef enum logic [ACT_W-1:0] {
        ACT_ROOT  = 2'd0,
        ACT_LEFT  = 2'd1,
        ACT_RIGHT = 2'd2,
        ACT_DUMP  = 2'd3
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK            = 3'd0,
        ST_ROOT_EXISTS   = 3'd1,
        ST_NOT_FOUND     = 3'd2,
        ST_OVERFLOW      = 3'd3,
        ST_CHILD_PRESENT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_SCAN,
        S_CHECK,
        S_EMIT,
        S_DUMP_RD,
        S_DUMP_WR
    } fsm_state_t;

    typedef struct packed {
        logic    in_ready;
        logic    rd_issue;
        logic    capture;
        logic    wr_root;
        logic    wr_child;
        logic    set_status;
        status_t status;
        logic    emit_status;
        logic    emit_slot;
    } dp_cmd_t;

    typedef struct packed {
        logic    in_valid;
        action_t in_action;
        logic    hit;
        logic    in_range;
        logic    rd_vld;
        logic    root_present;
        logic    child_over;
        logic    child_present;
        logic    out_free;
        logic    last_slot;
    } dp_sts_t;

endpackage

`default_nettype wire

/* design/abti_if.sv */
// request, response and configuration channel interfaces
`default_nettype none

interface abti_req_if import abti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] parent_value;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output action, output parent_value, output new_value,
                    input ready);
    modport sink   (input valid, input action, input parent_value, input new_value,
                    output ready);
endinterface

interface abti_rsp_if import abti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [SLOT_W-1:0]       slot_index;
    logic signed [VAL_W-1:0] slot_value;
    logic                    slot_present;
    logic                    last;

    modport source (output valid, output status, output slot_index, output slot_value,
                    output slot_present, output last, input ready);
    modport sink   (input valid, input status, input slot_index, input slot_value,
                    input slot_present, input last, output ready);
endinterface

interface abti_cfg_if import abti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/abti_dp.sv */
// datapath: slot memory, presence bits, scan pipeline and output register
`default_nettype none

module abti_dp import abti_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    abti_req_if.sink    req,
    abti_rsp_if.source  rsp,
    abti_cfg_if.sink    cfg,
    input  wire dp_cmd_t cmd,
    output dp_sts_t     sts
);

    localparam int AW = $clog2(MAX_NODES + 1);
    localparam logic [SLOT_W-1:0] MAX_SLOT = SLOT_W'(MAX_NODES);

    logic [SLOT_W-1:0]       tree_size_reg;
    logic [SLOT_W-1:0]       size;
    action_t                 act_reg;
    logic [VAL_W-1:0]        parent_reg;
    logic [VAL_W-1:0]        newv_reg;
    logic [SLOT_W:0]         idx_reg;
    logic [VAL_W-1:0]        rd_data_reg;
    logic                    rd_pres_reg;
    logic [SLOT_W-1:0]       rd_idx_reg;
    logic                    rd_vld_reg;
    logic [SLOT_W-1:0]       found_reg;
    status_t                 status_reg;
    logic [MAX_NODES:0]      present_reg;
    logic [VAL_W-1:0]        node_mem [0:MAX_NODES];

    logic                    out_vld_reg;
    status_t                 out_status_reg;
    logic [SLOT_W-1:0]       out_idx_reg;
    logic [VAL_W-1:0]        out_val_reg;
    logic                    out_pres_reg;
    logic                    out_last_reg;

    logic [SLOT_W:0]         child;
    logic                    child_over;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic                    accept;
    logic                    out_free;

    // effective size, clamped to 1..MAX_NODES
    always_comb
    begin
        if (tree_size_reg == '0)
        begin
            size = SLOT_W'(1);
        end
        else if (tree_size_reg > MAX_SLOT)
        begin
            size = MAX_SLOT;
        end
        else
        begin
            size = tree_size_reg;
        end
    end

    assign accept     = req.valid && req.ready;
    assign child      = {found_reg, (act_reg == ACT_RIGHT)};
    assign child_over = child > {1'b0, size};
    assign wr_en      = cmd.wr_root || cmd.wr_child;
    assign wr_addr    = cmd.wr_root ? AW'(1) : child[AW-1:0];
    assign out_free   = !out_vld_reg || rsp.ready;

    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        sts.in_valid      = req.valid;
        sts.in_action     = action_t'(req.action);
        sts.hit           = rd_vld_reg && rd_pres_reg && (rd_data_reg == parent_reg);
        sts.in_range      = idx_reg <= {1'b0, size};
        sts.rd_vld        = rd_vld_reg;
        sts.root_present  = present_reg[1];
        sts.child_over    = child_over;
        sts.child_present = !child_over && present_reg[child[AW-1:0]];
        sts.out_free      = out_free;
        sts.last_slot     = rd_idx_reg == size;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_size_reg <= TREE_SIZE_RST;
            present_reg   <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                tree_size_reg <= cfg.data;
            end
            if (wr_en)
            begin
                present_reg[wr_addr] <= 1'b1;
            end
            if (accept)
            begin
                idx_reg <= (SLOT_W + 1)'(1);
            end
            else if (cmd.rd_issue)
            begin
                idx_reg <= idx_reg + (SLOT_W + 1)'(1);
            end
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.emit_status || cmd.emit_slot)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= newv_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= node_mem[idx_reg[AW-1:0]];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action_t'(req.action);
            parent_reg <= req.parent_value;
            newv_reg   <= req.new_value;
        end
        if (cmd.rd_issue)
        begin
            rd_pres_reg <= present_reg[idx_reg[AW-1:0]];
            rd_idx_reg  <= idx_reg[SLOT_W-1:0];
        end
        if (cmd.capture)
        begin
            found_reg <= rd_idx_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.emit_status)
        begin
            out_status_reg <= status_reg;
            out_idx_reg    <= '0;
            out_val_reg    <= '0;
            out_pres_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_slot)
        begin
            out_status_reg <= ST_OK;
            out_idx_reg    <= rd_idx_reg;
            out_val_reg    <= rd_pres_reg ? rd_data_reg : '0;
            out_pres_reg   <= rd_pres_reg;
            out_last_reg   <= rd_idx_reg == size;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot_index   = out_idx_reg;
    assign rsp.slot_value   = out_val_reg;
    assign rsp.slot_present = out_pres_reg;
    assign rsp.last         = out_last_reg;

endmodule

`default_nettype wire

/* design/abti_ctrl.sv */
// controller state machine for root set, child insert and dump
`default_nettype none

module abti_ctrl import abti_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.in_ready    = 1'b0;
        cmd.rd_issue    = 1'b0;
        cmd.capture     = 1'b0;
        cmd.wr_root     = 1'b0;
        cmd.wr_child    = 1'b0;
        cmd.set_status  = 1'b0;
        cmd.status      = ST_OK;
        cmd.emit_status = 1'b0;
        cmd.emit_slot   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    case (sts.in_action)
                        ACT_ROOT:  state_next = S_ROOT;
                        ACT_LEFT:  state_next = S_SCAN;
                        ACT_RIGHT: state_next = S_SCAN;
                        ACT_DUMP:  state_next = S_DUMP_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ROOT:
            begin
                cmd.set_status = 1'b1;
                cmd.status     = sts.root_present ? ST_ROOT_EXISTS : ST_OK;
                cmd.wr_root    = !sts.root_present;
                state_next     = S_EMIT;
            end
            S_SCAN:
            begin
                // first present slot holding the parent value
                if (sts.hit)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
                else if (!sts.in_range && !sts.rd_vld)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.rd_issue = sts.in_range;
                end
            end
            S_CHECK:
            begin
                cmd.set_status = 1'b1;
                if (sts.child_over)
                begin
                    cmd.status = ST_OVERFLOW;
                end
                else if (sts.child_present)
                begin
                    cmd.status = ST_CHILD_PRESENT;
                end
                else
                begin
                    cmd.status   = ST_OK;
                    cmd.wr_child = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DUMP_WR;
            end
            S_DUMP_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_slot = 1'b1;
                    if (sts.last_slot)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/array_binary_tree_insert.sv */
// top level of the array binary tree block
//
// Keeps a binary tree in slots 1..tree_size (slot i has children 2i and 2i+1),
// with values in a slot memory with one write port and one registered read
// port and presence bits in flip-flops that reset clears. One request is
// worked on at a time. An insert scans the slots through the memory's
// registered read port, one slot per cycle. A dump streams one beat per slot,
// one beat per cycle while the response channel takes them, the last beat
// flagged by last. The result register lets the final beat wait on the
// response channel while the next request is taken. The user must write
// tree_size through cfg only while the block is idle; the block itself does
// not enforce this. 0 acts as 1.
`default_nettype none

module array_binary_tree_insert import abti_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    abti_req_if.sink   req,
    abti_rsp_if.source rsp,
    abti_cfg_if.sink   cfg
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    abti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    abti_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_status || cmd.emit_slot) |-> sts.out_free)
        else $error("result loaded while output register busy");

    a_child_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_child |-> (!sts.child_over && !sts.child_present))
        else $error("child written over a present slot or past tree size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.last && rsp.slot_index == '0))
        else $error("error status beat not a single final beat");
`endif

endmodule

`default_nettype wire
